/* design/spa_pkg.sv */
// Package for the SHAP pair accumulator: sizes, command and register codes,
// sequencer states and the per-leaf statistics record.
// No dependencies.
package spa_pkg;

    localparam int NUM_LEAVES   = 256;
    localparam int NUM_FEATURES = 10;
    localparam int MAX_DEPTH    = 10;
    localparam int CHUNK_BITS   = 32;
    localparam int NUM_CHUNKS   = NUM_LEAVES / CHUNK_BITS;
    localparam int WT_SIZE      = MAX_DEPTH * MAX_DEPTH;
    localparam int LEAF_W       = $clog2(NUM_LEAVES);
    localparam int CHUNK_W      = $clog2(NUM_CHUNKS);
    localparam int BIT_W        = $clog2(CHUNK_BITS);
    localparam int WT_W         = $clog2(WT_SIZE);
    localparam int FEAT_W       = $clog2(NUM_FEATURES + 1);
    localparam int CNT_W        = 7;
    localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;
    localparam int SHAP_W       = 56;
    localparam int PROD_W       = 49;

    localparam logic [2:0] CMD_WEIGHT = 3'd0;
    localparam logic [2:0] CMD_LOGIT  = 3'd1;
    localparam logic [2:0] CMD_FORE   = 3'd2;
    localparam logic [2:0] CMD_BACK   = 3'd3;
    localparam logic [2:0] CMD_END    = 3'd4;

    localparam logic REG_CLASS = 1'b0;
    localparam logic REG_FEAT  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD_RD,
        S_UPD_WR,
        S_WLK_RD,
        S_WLK_CHK,
        S_WLK_WRD,
        S_WLK_MUL,
        S_WLK_ACC,
        S_EMIT_LD,
        S_EMIT_WAIT
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0]        diff;
        logic [CNT_W-1:0]        fo_cnt;
        logic                    covered;
        logic [NUM_FEATURES-1:0] fo_bits;
        logic [NUM_FEATURES-1:0] plus;
        logic [NUM_FEATURES-1:0] minus;
    } stat_t;

    localparam int STAT_W = $bits(stat_t);
    localparam stat_t STAT_RESET = '{diff: '0, fo_cnt: '0, covered: 1'b1,
                                     fo_bits: '0, plus: '0, minus: '0};

endpackage

/* design/spa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module spa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/shap_pair_accumulator_top.sv */
// SHAP pair accumulator, top level.
// Depends on spa_pkg and spa_ram.
//
// Usage: the input channel carries commands (weight load, logit load,
// foreground chunk, background chunk, end marker) with a valid/ready
// transfer; the output channel carries one SHAP result per feature.
// Configuration registers class_id and features_in_use are written through
// cfg_write/cfg_index/cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce. Table loads and
// foreground chunks are stored while the block stays idle; an end marker
// is registered into the output register. A background chunk in range does
// a read-modify-write of the leaf statistics memory for each of its leaves.
// A run-completing chunk then walks all 256 leaves, each active feature of
// each covered leaf passing the one multiplier and one saturating adder.
// Input is not ready while a chunk, the walk or results are in progress.
// When the receiver stalls, the result holds in the output register.
// Reset restores the register defaults, clears per-leaf statistics via
// valid bits and zeroes the sums; table contents are undefined until loaded.
module shap_pair_accumulator_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         command,
    input  logic [7:0]         table_address,
    input  logic signed [31:0] table_value,
    input  logic [31:0]        match_bits,
    input  logic [15:0]        sample_id,
    input  logic               last_chunk,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        result_sample,
    output logic               end_marker,
    output logic signed [8:0]  result_class,
    output logic [5:0]         feature_index,
    output logic signed [55:0] shap_value,
    output logic               last,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [8:0]         cfg_data
);
    import spa_pkg::*;

    state_t state_reg, state_next;

    logic signed [8:0] class_id_reg;
    logic [6:0]        fiu_reg;
    logic [FEAT_W-1:0] nf;

    logic [CHUNK_BITS-1:0] fore_rdata;
    logic [CHUNK_BITS-1:0] back_reg;
    logic                  lastc_reg;
    logic [15:0]           sid_reg;
    logic [FEAT_W-1:0]     pc_reg;
    logic [LEAF_W-1:0]     leaf_reg;
    logic [FEAT_W-1:0]     j_reg;
    logic [NUM_LEAVES-1:0] valid_reg;
    logic signed [SHAP_W-1:0] sums_reg [NUM_FEATURES];
    stat_t                 ent_reg;
    logic                  wvalid_reg, pos_reg, neg_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic                  out_valid_reg;
    logic [15:0]           res_sample_reg;
    logic                  end_marker_reg;
    logic signed [8:0]     res_class_reg;
    logic [5:0]            feat_reg;
    logic signed [SHAP_W-1:0] shap_reg;
    logic                  last_reg;

    logic in_fire, out_fire, run_full, leaf_end, chunk_end, j_end;

    logic [STAT_W-1:0] stat_rdata;
    stat_t             ent, upd;
    logic              stat_we;
    logic [15:0]       w_rdata;
    logic signed [31:0] l_rdata;
    logic [NUM_FEATURES-1:0] pbit;
    logic              f_bit, g_bit;

    logic [CNT_W-1:0]  col;
    logic              wvalid;
    logic [WT_W-1:0]   widx;
    logic signed [SHAP_W:0] acc_sum;
    logic signed [SHAP_W-1:0] acc_sat;
    logic signed [PROD_W-1:0] term;

    always_comb
    begin
        if (fiu_reg == 7'd0)
        begin
            nf = FEAT_W'(1);
        end
        else if (fiu_reg > 7'(NUM_FEATURES))
        begin
            nf = FEAT_W'(NUM_FEATURES);
        end
        else
        begin
            nf = FEAT_W'(fiu_reg);
        end
    end

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign run_full  = ({1'b0, pc_reg} + 1'b1) >= {1'b0, nf};
    assign leaf_end  = (leaf_reg == LEAF_W'(NUM_LEAVES - 1));
    assign chunk_end = (leaf_reg[BIT_W-1:0] == BIT_W'(CHUNK_BITS - 1));
    assign j_end     = (j_reg == nf - 1'b1);

    assign ent = valid_reg[leaf_reg] ? stat_t'(stat_rdata) : STAT_RESET;

    spa_ram #(.WIDTH(CHUNK_BITS), .DEPTH(NUM_CHUNKS)) u_fore_ram (
        .clk   (clk),
        .we    (in_fire && command == CMD_FORE && table_address < 8'(NUM_CHUNKS)),
        .waddr (table_address[CHUNK_W-1:0]),
        .wdata (match_bits),
        .raddr (leaf_reg[LEAF_W-1:BIT_W]),
        .rdata (fore_rdata)
    );

    spa_ram #(.WIDTH(STAT_W), .DEPTH(NUM_LEAVES)) u_stat_ram (
        .clk   (clk),
        .we    (stat_we),
        .waddr (leaf_reg),
        .wdata (upd),
        .raddr (leaf_reg),
        .rdata (stat_rdata)
    );

    spa_ram #(.WIDTH(16), .DEPTH(WT_SIZE)) u_weight_ram (
        .clk   (clk),
        .we    (in_fire && command == CMD_WEIGHT && table_address < 8'(WT_SIZE)),
        .waddr (table_address[WT_W-1:0]),
        .wdata (table_value[15:0]),
        .raddr (widx),
        .rdata (w_rdata)
    );

    spa_ram #(.WIDTH(32), .DEPTH(NUM_LEAVES)) u_logit_ram (
        .clk   (clk),
        .we    (in_fire && command == CMD_LOGIT),
        .waddr (table_address[LEAF_W-1:0]),
        .wdata (table_value),
        .raddr (leaf_reg),
        .rdata (l_rdata)
    );

    // Leaf statistics update for one background bit.
    always_comb
    begin
        f_bit = fore_rdata[leaf_reg[BIT_W-1:0]];
        g_bit = back_reg[leaf_reg[BIT_W-1:0]];
        pbit  = NUM_FEATURES'(1) << pc_reg;
        upd   = ent;
        if ((f_bit ^ g_bit) && ent.diff < CNT_MAX)
        begin
            upd.diff = ent.diff + 1'b1;
        end
        if (f_bit && !g_bit)
        begin
            if (ent.fo_cnt < CNT_MAX)
            begin
                upd.fo_cnt = ent.fo_cnt + 1'b1;
            end
            upd.fo_bits = ent.fo_bits | pbit;
            upd.plus    = ent.plus | pbit;
        end
        if (!f_bit && g_bit)
        begin
            upd.minus = ent.minus | pbit;
        end
        if (!(f_bit || g_bit))
        begin
            upd.covered = 1'b0;
        end
    end

    // Weight index for the current leaf and feature.
    always_comb
    begin
        col    = ent_reg.fo_cnt - CNT_W'(ent_reg.fo_bits[j_reg]);
        wvalid = (ent_reg.fo_cnt >= CNT_W'(ent_reg.fo_bits[j_reg])) &&
                 (ent_reg.diff < CNT_W'(MAX_DEPTH)) && (col < CNT_W'(MAX_DEPTH));
        widx   = WT_W'(ent_reg.diff[3:0] * WT_W'(MAX_DEPTH)) + WT_W'(col[3:0]);
    end

    // Saturating accumulation.
    always_comb
    begin
        term    = neg_reg ? -prod_reg : prod_reg;
        acc_sum = {sums_reg[j_reg][SHAP_W-1], sums_reg[j_reg]} + (SHAP_W+1)'(term);
        if (acc_sum[SHAP_W] != acc_sum[SHAP_W-1])
        begin
            acc_sat = acc_sum[SHAP_W] ? {1'b1, {(SHAP_W-1){1'b0}}}
                                      : {1'b0, {(SHAP_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_sum[SHAP_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && command == CMD_BACK)
                begin
                    if (table_address < 8'(NUM_CHUNKS))
                    begin
                        state_next = S_UPD_RD;
                    end
                    else if (last_chunk && run_full)
                    begin
                        state_next = S_WLK_RD;
                    end
                end
            end
            S_UPD_RD:
            begin
                state_next = S_UPD_WR;
            end
            S_UPD_WR:
            begin
                if (chunk_end)
                begin
                    state_next = (lastc_reg && run_full) ? S_WLK_RD : S_IDLE;
                end
                else
                begin
                    state_next = S_UPD_RD;
                end
            end
            S_WLK_RD:
            begin
                state_next = S_WLK_CHK;
            end
            S_WLK_CHK:
            begin
                if (ent.covered)
                begin
                    state_next = S_WLK_WRD;
                end
                else
                begin
                    state_next = leaf_end ? S_EMIT_LD : S_WLK_RD;
                end
            end
            S_WLK_WRD:
            begin
                state_next = S_WLK_MUL;
            end
            S_WLK_MUL:
            begin
                state_next = S_WLK_ACC;
            end
            S_WLK_ACC:
            begin
                if (j_end)
                begin
                    state_next = leaf_end ? S_EMIT_LD : S_WLK_RD;
                end
                else
                begin
                    state_next = S_WLK_WRD;
                end
            end
            S_EMIT_LD:
            begin
                state_next = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                if (out_fire)
                begin
                    state_next = last_reg ? S_IDLE : S_EMIT_LD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        stat_we = (state_reg == S_UPD_WR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            class_id_reg  <= -9'sd1;
            fiu_reg       <= 7'd10;
            pc_reg        <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_FEATURES; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                if (cfg_index == REG_CLASS)
                begin
                    class_id_reg <= cfg_data;
                end
                else if (cfg_index == REG_FEAT)
                begin
                    fiu_reg <= cfg_data[6:0];
                end
            end
            if (in_fire && command == CMD_END)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (state_reg == S_EMIT_LD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == S_IDLE && in_fire && command == CMD_BACK &&
                 table_address >= 8'(NUM_CHUNKS) && last_chunk) ||
                (state_reg == S_UPD_WR && chunk_end && lastc_reg))
            begin
                pc_reg <= pc_reg + 1'b1;
            end
            if (stat_we)
            begin
                valid_reg[leaf_reg] <= 1'b1;
            end
            if (state_reg == S_WLK_ACC && (neg_reg || pos_reg))
            begin
                sums_reg[j_reg] <= acc_sat;
            end
            if (state_reg == S_EMIT_WAIT && out_fire && last_reg)
            begin
                pc_reg    <= '0;
                valid_reg <= '0;
                for (int i = 0; i < NUM_FEATURES; i++)
                begin
                    sums_reg[i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && command == CMD_BACK)
        begin
            back_reg  <= match_bits;
            lastc_reg <= last_chunk;
            sid_reg   <= sample_id;
            leaf_reg  <= (table_address < 8'(NUM_CHUNKS))
                         ? {table_address[CHUNK_W-1:0], {BIT_W{1'b0}}} : '0;
        end
        case (state_reg)
            S_UPD_WR:
            begin
                if (chunk_end)
                begin
                    leaf_reg <= '0;
                end
                else
                begin
                    leaf_reg <= leaf_reg + 1'b1;
                end
            end
            S_WLK_CHK:
            begin
                ent_reg <= ent;
                j_reg   <= '0;
                if (!ent.covered)
                begin
                    leaf_reg <= leaf_reg + 1'b1;
                end
            end
            S_WLK_WRD:
            begin
                wvalid_reg <= wvalid;
                pos_reg    <= ent_reg.plus[j_reg] && !ent_reg.minus[j_reg];
                neg_reg    <= ent_reg.minus[j_reg] && !ent_reg.plus[j_reg];
            end
            S_WLK_MUL:
            begin
                prod_reg <= wvalid_reg ? PROD_W'($signed({1'b0, w_rdata}) * l_rdata)
                                       : '0;
            end
            S_WLK_ACC:
            begin
                if (j_end)
                begin
                    leaf_reg <= leaf_reg + 1'b1;
                    j_reg    <= '0;
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            S_EMIT_LD:
            begin
                res_sample_reg <= sid_reg;
                end_marker_reg <= 1'b0;
                res_class_reg  <= class_id_reg;
                feat_reg       <= 6'(j_reg);
                shap_reg       <= sums_reg[j_reg];
                last_reg       <= j_end;
            end
            S_EMIT_WAIT:
            begin
                if (out_fire)
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (in_fire && command == CMD_END)
        begin
            res_sample_reg <= '0;
            end_marker_reg <= 1'b1;
            res_class_reg  <= class_id_reg;
            feat_reg       <= '0;
            shap_reg       <= '0;
            last_reg       <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_sample = res_sample_reg;
    assign end_marker    = end_marker_reg;
    assign result_class  = res_class_reg;
    assign feature_index = feat_reg;
    assign shap_value    = shap_reg;
    assign last          = last_reg;

endmodule

/* design/spa_checker.sv */
// Port-level checker for the SHAP pair accumulator and its bind statement.
// Depends on shap_pair_accumulator_top.
module spa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               end_marker,
    input logic               last,
    input logic [5:0]         feature_index,
    input logic signed [55:0] shap_value
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Result transfer dropped while stalled.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(shap_value))
        else $error("Result value changed while stalled.");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_marker |-> last && shap_value == 0 && feature_index == 0)
        else $error("End result is malformed.");

    a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("Input ready while a result is pending.");

endmodule

bind shap_pair_accumulator_top spa_checker u_spa_checker (.*);

/* bench/shap_pair_accumulator_top_tb.sv */
// Self-checking testbench for shap_pair_accumulator_top: it drives commands and chunk
// transfers, predicts every SHAP result with its own model and checks the results in order.
// Depends on spa_pkg and the design sources.
module shap_pair_accumulator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spa_pkg::*;

    typedef struct {
        logic [15:0]        sample;
        logic               endm;
        logic signed [8:0]  cls;
        logic [5:0]         feat;
        logic signed [55:0] value;
        logic               lst;
    } shap_result_t;

    class shap_scoreboard;
        shap_result_t            pending_q[$];
        int                      fails;
        logic signed [8:0]       class_reg;
        logic [6:0]              feat_reg;
        logic [31:0]             fore_mem[NUM_CHUNKS];
        logic [15:0]             weight_mem[WT_SIZE];
        logic signed [31:0]      logit_mem[NUM_LEAVES];
        stat_t                   leaf_stat[NUM_LEAVES];
        int                      pairs_seen;
        longint                  sums[NUM_FEATURES];

        function new();
            fails     = 0;
            class_reg = -9'sd1;
            feat_reg  = 7'd10;
            clear_run();
        endfunction

        function void clear_run();
            foreach (leaf_stat[l])
                leaf_stat[l] = STAT_RESET;
            foreach (sums[j])
                sums[j] = 0;
            pairs_seen = 0;
        endfunction

        function void write_reg(logic idx, logic [8:0] data);
            if (idx == REG_CLASS)
                class_reg = data;
            else
                feat_reg = data[6:0];
        endfunction

        function int active_features();
            int f;
            f = int'(feat_reg);
            if (f == 0)
                f = 1;
            if (f > NUM_FEATURES)
                f = NUM_FEATURES;
            return f;
        endfunction

        function void apply_back(int chunk, logic [31:0] back);
            int leaf;
            logic f;
            logic g;
            for (int b = 0; b < CHUNK_BITS; b++)
            begin
                leaf = chunk * CHUNK_BITS + b;
                f = fore_mem[chunk][b];
                g = back[b];
                if ((f ^ g) && leaf_stat[leaf].diff < CNT_MAX)
                    leaf_stat[leaf].diff++;
                if (f && !g)
                begin
                    if (leaf_stat[leaf].fo_cnt < CNT_MAX)
                        leaf_stat[leaf].fo_cnt++;
                    leaf_stat[leaf].fo_bits[pairs_seen] = 1'b1;
                    leaf_stat[leaf].plus[pairs_seen] = 1'b1;
                end
                if (!f && g)
                    leaf_stat[leaf].minus[pairs_seen] = 1'b1;
                if (!(f | g))
                    leaf_stat[leaf].covered = 1'b0;
            end
        endfunction

        function void accumulate_leaves(int nf);
            int u;
            int row;
            int col;
            int sgn;
            longint w;
            longint term;
            longint hi;
            longint lo;
            hi = 64'sh7FFFFFFFFFFFFF;
            lo = -hi - 1;
            for (int l = 0; l < NUM_LEAVES; l++)
            begin
                if (!leaf_stat[l].covered)
                    continue;
                for (int j = 0; j < nf; j++)
                begin
                    u = int'(leaf_stat[l].fo_bits[j]);
                    row = int'(leaf_stat[l].diff);
                    sgn = int'(leaf_stat[l].plus[j]) - int'(leaf_stat[l].minus[j]);
                    w = 0;
                    if (int'(leaf_stat[l].fo_cnt) >= u)
                    begin
                        col = int'(leaf_stat[l].fo_cnt) - u;
                        if (row < MAX_DEPTH && col < MAX_DEPTH)
                            w = longint'(weight_mem[row * MAX_DEPTH + col]);
                    end
                    term = w * longint'(logit_mem[l]);
                    if (sgn < 0)
                        term = -term;
                    if (sgn != 0)
                    begin
                        sums[j] = sums[j] + term;
                        if (sums[j] > hi)
                            sums[j] = hi;
                        if (sums[j] < lo)
                            sums[j] = lo;
                    end
                end
            end
        endfunction

        function void note_input(logic [2:0] cmd, logic [7:0] addr, logic [31:0] val,
                                 logic [31:0] bits, logic [15:0] sid, logic lastc);
            int nf;
            shap_result_t r;
            case (cmd)
                CMD_WEIGHT: if (addr < WT_SIZE) weight_mem[addr] = val[15:0];
                CMD_LOGIT:  if (addr < NUM_LEAVES) logit_mem[addr] = val;
                CMD_FORE:   if (addr < NUM_CHUNKS) fore_mem[addr] = bits;
                CMD_BACK:
                begin
                    if (addr < NUM_CHUNKS)
                        apply_back(int'(addr), bits);
                    if (lastc)
                    begin
                        pairs_seen++;
                        nf = active_features();
                        if (pairs_seen >= nf)
                        begin
                            accumulate_leaves(nf);
                            for (int j = 0; j < nf; j++)
                            begin
                                r.sample = sid;
                                r.endm   = 1'b0;
                                r.cls    = class_reg;
                                r.feat   = 6'(j);
                                r.value  = sums[j][55:0];
                                r.lst    = (j == nf - 1);
                                pending_q = {pending_q, r};
                            end
                            clear_run();
                        end
                    end
                end
                CMD_END:
                begin
                    r.sample = '0;
                    r.endm   = 1'b1;
                    r.cls    = class_reg;
                    r.feat   = '0;
                    r.value  = '0;
                    r.lst    = 1'b1;
                    pending_q = {pending_q, r};
                end
                default: ;
            endcase
        endfunction

        function void check_result(shap_result_t got);
            shap_result_t exp_r;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result: feature_index %0d shap_value %0d",
                       got.feat, got.value);
                fails++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.sample !== exp_r.sample)
            begin
                $error("result_sample: expected %0d, actual %0d", exp_r.sample, got.sample);
                fails++;
            end
            if (got.endm !== exp_r.endm)
            begin
                $error("end_marker: expected %0d, actual %0d", exp_r.endm, got.endm);
                fails++;
            end
            if (got.cls !== exp_r.cls)
            begin
                $error("result_class: expected %0d, actual %0d", exp_r.cls, got.cls);
                fails++;
            end
            if (got.feat !== exp_r.feat)
            begin
                $error("feature_index: expected %0d, actual %0d", exp_r.feat, got.feat);
                fails++;
            end
            if (got.value !== exp_r.value)
            begin
                $error("shap_value: expected %0d, actual %0d", exp_r.value, got.value);
                fails++;
            end
            if (got.lst !== exp_r.lst)
            begin
                $error("last: expected %0d, actual %0d", exp_r.lst, got.lst);
                fails++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 30000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         command = '0;
    logic [7:0]         table_address = '0;
    logic signed [31:0] table_value = '0;
    logic [31:0]        match_bits = '0;
    logic [15:0]        sample_id = '0;
    logic               last_chunk = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b1;
    logic [15:0]        result_sample;
    logic               end_marker;
    logic signed [8:0]  result_class;
    logic [5:0]         feature_index;
    logic signed [55:0] shap_value;
    logic               last;
    logic               cfg_write = 1'b0;
    logic               cfg_index = 1'b0;
    logic [8:0]         cfg_data = '0;

    shap_scoreboard     sb = new();
    bit                 idle_on = 1'b1;
    int                 quiet_cycles = 0;
    logic [31:0]        fore_sent[NUM_CHUNKS];
    int                 items_sent = 0;

    shap_pair_accumulator_top i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        shap_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.sample = result_sample;
            got.endm   = end_marker;
            got.cls    = result_class;
            got.feat   = feature_index;
            got.value  = shap_value;
            got.lst    = last;
            sb.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_ready <= 1'b1;
            end
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    task automatic send_item(logic [2:0] cmd, logic [7:0] addr, logic [31:0] val,
                             logic [31:0] bits, logic [15:0] sid, logic lastc);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        table_address <= addr;
        table_value   <= val;
        match_bits    <= bits;
        sample_id     <= sid;
        last_chunk    <= lastc;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(cmd, addr, val, bits, sid, lastc);
        if (cmd == CMD_FORE && addr < NUM_CHUNKS)
            fore_sent[addr] = bits;
        items_sent++;
    endtask

    task automatic drain_and_configure(logic [8:0] class_val, logic [6:0] feat_val);
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_CLASS;
        cfg_data  <= class_val;
        @(posedge clk);
        sb.write_reg(REG_CLASS, class_val);
        cfg_index <= REG_FEAT;
        cfg_data  <= {2'b00, feat_val};
        @(posedge clk);
        sb.write_reg(REG_FEAT, {2'b00, feat_val});
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] back_pattern(int chunk);
        case ($urandom_range(0, 4))
            0:       return $urandom();
            1:       return ~fore_sent[chunk];
            2:       return fore_sent[chunk] | $urandom();
            3:       return ~fore_sent[chunk] ^ ($urandom() & $urandom() & $urandom());
            default: return $urandom() | $urandom();
        endcase
    endfunction

    task automatic send_pair(logic [15:0] sid);
        int n;
        int a;
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++)
        begin
            a = ($urandom_range(0, 15) == 0) ? $urandom_range(NUM_CHUNKS, 255)
                                              : $urandom_range(0, NUM_CHUNKS - 1);
            send_item(CMD_BACK, 8'(a), $urandom(),
                      (a < NUM_CHUNKS) ? back_pattern(a) : $urandom(), sid, k == n - 1);
        end
    endtask

    initial
    begin
        int sel;
        int a;
        logic [15:0] sid;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        drain_and_configure(-9'sd1, 7'd1);
        for (int i = 0; i < WT_SIZE; i++)
            send_item(CMD_WEIGHT, 8'(i), $urandom(), $urandom(), 16'($urandom()),
                      1'($urandom()));
        for (int i = 0; i < NUM_LEAVES; i++)
            send_item(CMD_LOGIT, 8'(i), $urandom(), $urandom(), 16'($urandom()),
                      1'($urandom()));
        for (int i = 0; i < NUM_CHUNKS; i++)
            send_item(CMD_FORE, 8'(i), $urandom(), $urandom(), 16'($urandom()), 1'b0);

        send_item(CMD_WEIGHT, 8'd0, 32'hFFFF_FFFF, '0, '0, 1'b0);
        send_item(CMD_WEIGHT, 8'(WT_SIZE - 1), 32'h0000_FFFF, '1, '1, 1'b1);
        send_item(CMD_WEIGHT, 8'd200, 32'h0, '0, '0, 1'b0);
        send_item(CMD_WEIGHT, 8'd10, 32'h0000_FFFF, '0, '0, 1'b0);
        send_item(CMD_LOGIT, 8'd0, 32'h8000_0000, '0, '0, 1'b0);
        send_item(CMD_LOGIT, 8'(NUM_LEAVES - 1), 32'h7FFF_FFFF, '0, '0, 1'b0);
        send_item(CMD_FORE, 8'd200, '0, '1, '0, 1'b0);
        send_item(CMD_END, 8'd0, '0, '0, 16'hFFFF, 1'b1);
        send_item(CMD_END + 3'd1, 8'd5, '1, '1, '1, 1'b1);
        send_item(CMD_END + 3'd2, 8'd0, '0, '0, '0, 1'b1);
        send_item(3'd7, 8'd255, '1, '1, '1, 1'b1);
        send_item(CMD_BACK, 8'd255, '0, '1, 16'h1234, 1'b1);
        send_item(CMD_FORE, 8'd0, '0, '1, '0, 1'b0);
        send_item(CMD_BACK, 8'd0, '0, '0, 16'hFFFF, 1'b1);
        send_item(CMD_BACK, 8'd0, '0, '1, 16'h0000, 1'b0);
        send_item(CMD_BACK, 8'd0, '0, '1, 16'h0001, 1'b1);

        drain_and_configure(9'sd255, 7'd64);
        send_item(CMD_END, 8'd0, '0, '0, '0, 1'b0);
        for (int p = 0; p < NUM_FEATURES; p++)
            send_pair(16'($urandom()));

        items_sent = 0;
        for (int phase = 0; items_sent < 210; phase++)
        begin
            case (phase % 4)
                0:       drain_and_configure(9'sd0, 7'd10);
                1:       drain_and_configure(9'($urandom_range(0, 511)),
                                             7'($urandom_range(1, 4)));
                2:       drain_and_configure(-9'sd1, 7'd1);
                default: drain_and_configure(9'($urandom()), 7'($urandom_range(1, 64)));
            endcase
            if (items_sent > 170)
                idle_on = 1'b0;
            sid = 16'($urandom());
            for (int k = 0; k < 40; k++)
            begin
                sel = $urandom_range(0, 19);
                if (sel < 14)
                    send_pair(sid);
                else if (sel == 14)
                begin
                    a = $urandom_range(0, NUM_CHUNKS - 1);
                    send_item(CMD_FORE, 8'(a), $urandom(), $urandom(), 16'($urandom()),
                              1'($urandom()));
                end
                else if (sel == 15)
                    send_item(CMD_WEIGHT, 8'($urandom_range(0, 255)), $urandom(), $urandom(),
                              16'($urandom()), 1'($urandom()));
                else if (sel == 16)
                    send_item(CMD_LOGIT, 8'($urandom()), $urandom(), $urandom(),
                              16'($urandom()), 1'($urandom()));
                else if (sel == 17)
                    send_item(CMD_END, 8'($urandom()), $urandom(), $urandom(),
                              16'($urandom()), 1'($urandom()));
                else if (sel == 18)
                    send_item(3'($urandom_range(CMD_END + 1, 7)), 8'($urandom()), $urandom(),
                              $urandom(), 16'($urandom()), 1'($urandom()));
                else
                    sid = 16'($urandom());
            end
        end

        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.fails == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
